// ===== rtl/sobel_pkg.sv =====
`default_nettype none
package sobel_pkg;

  // Pixel and register widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned IMG_W_W  = 11;
  localparam int unsigned IMG_H_W  = 13;
  localparam int unsigned THR_W    = 11;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THR   = 2'd2;

  // Gradient and root widths
  localparam int unsigned ABS_W  = 11;
  localparam int unsigned SQ_W   = 22;
  localparam int unsigned ROOT_STEPS = 11;
  localparam logic [SQ_W-1:0] ROOT_TOP = SQ_W'(1) << 20;
  localparam logic [SQ_W-1:0] SAT_MAX  = SQ_W'(255);

  // Per-item command: which window taps are padded, whether it emits, whether it is last
  typedef struct packed {
    logic emit;
    logic top_z;
    logic bot_z;
    logic left_z;
    logic right_z;
    logic last;
  } sobel_cmd_t;

  // Datapath operations issued by the controller
  typedef struct packed {
    logic ld_win;
    logic ld_grad;
    logic ld_sq;
    logic root_step;
    logic out_load;
    logic out_drop;
  } sobel_op_t;

  // Datapath status
  typedef struct packed {
    logic out_free;
  } sobel_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sobel_ram.sv =====
`default_nettype none
module sobel_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/sobel_dp.sv =====
`default_nettype none
module sobel_dp import sobel_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sobel_op_t        op_i,
  input  wire sobel_cmd_t       cmd_i,
  input  wire logic [CW-1:0]    raddr_i,
  input  wire logic [CW-1:0]    waddr_i,
  input  wire logic [PIX_W-1:0] pix_i,
  input  wire logic [THR_W-1:0] thr_i,
  output      sobel_stat_t      stat_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [PIX_W-1:0] out_data_o,
  output      logic             out_last_o
);

  logic [PIX_W-1:0] top_rd, mid_rd;
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] p [9];
  logic [PIX_W+2:0] sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [PIX_W+3:0] gx, gy;
  logic [ABS_W-1:0] ax_q, ay_q;
  logic [SQ_W-1:0] s_q, tsq_q, v_q, res_q, bit_q, trial;
  logic last_q;
  logic out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_data_q;
  logic [PIX_W-1:0] res_sat;

  // Two previous rows; read at accept, written back in the cycle after
  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_two_above (
    .clk_i, .we_i(op_i.ld_win), .waddr_i(waddr_i), .wdata_i(mid_rd),
    .raddr_i(raddr_i), .rdata_o(top_rd)
  );
  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
    .clk_i, .we_i(op_i.ld_win), .waddr_i(waddr_i), .wdata_i(pix_i),
    .raddr_i(raddr_i), .rdata_o(mid_rd)
  );

  // 3x3 window shift
  always_ff @(posedge clk_i) begin
    if (op_i.ld_win) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_rd;
      win_q[5] <= mid_rd;
      win_q[8] <= pix_i;
    end
  end

  // Zero padding outside the image
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p[k] = win_q[k];
    end
    if (cmd_i.top_z) begin
      p[0] = '0; p[1] = '0; p[2] = '0;
    end
    if (cmd_i.bot_z) begin
      p[6] = '0; p[7] = '0; p[8] = '0;
    end
    if (cmd_i.left_z) begin
      p[0] = '0; p[3] = '0; p[6] = '0;
    end
    if (cmd_i.right_z) begin
      p[2] = '0; p[5] = '0; p[8] = '0;
    end
  end

  // Sobel sums
  assign sx_pos = (PIX_W+3)'(p[2]) + {p[5], 1'b0} + (PIX_W+3)'(p[8]);
  assign sx_neg = (PIX_W+3)'(p[0]) + {p[3], 1'b0} + (PIX_W+3)'(p[6]);
  assign sy_pos = (PIX_W+3)'(p[6]) + {p[7], 1'b0} + (PIX_W+3)'(p[8]);
  assign sy_neg = (PIX_W+3)'(p[0]) + {p[1], 1'b0} + (PIX_W+3)'(p[2]);
  assign gx = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
  assign gy = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});

  assign trial = res_q + bit_q;

  // Gradient, squares, then a bit-pair square root loop
  always_ff @(posedge clk_i) begin
    if (op_i.ld_grad) begin
      ax_q   <= ABS_W'(gx[PIX_W+3] ? -gx : gx);
      ay_q   <= ABS_W'(gy[PIX_W+3] ? -gy : gy);
      last_q <= cmd_i.last;
    end
    if (op_i.ld_sq) begin
      s_q   <= SQ_W'(ax_q * ax_q) + SQ_W'(ay_q * ay_q);
      v_q   <= SQ_W'(ax_q * ax_q) + SQ_W'(ay_q * ay_q);
      tsq_q <= SQ_W'(thr_i * thr_i);
      res_q <= '0;
      bit_q <= ROOT_TOP;
    end else if (op_i.root_step) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign res_sat = (res_q > SAT_MAX) ? PIX_W'(SAT_MAX) : res_q[PIX_W-1:0];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i.out_drop) begin
      out_valid_q <= 1'b0;
    end else if (op_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.out_load) begin
      out_data_q <= (s_q > tsq_q) ? res_sat : '0;
      out_last_q <= last_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/sobel_ctrl.sv =====
`default_nettype none
module sobel_ctrl import sobel_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned EW = ($clog2(MAX_WIDTH+1) > IMG_W_W) ?
                               $clog2(MAX_WIDTH+1) : IMG_W_W
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [PIX_W-1:0]     in_pix_i,
  input  wire logic                 in_flush_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire sobel_stat_t          stat_i,
  output      sobel_op_t            op_o,
  output      sobel_cmd_t           cmd_o,
  output      logic [CW-1:0]        raddr_o,
  output      logic [CW-1:0]        waddr_o,
  output      logic [PIX_W-1:0]     pix_o,
  output      logic [THR_W-1:0]     thr_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_GRAD = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic [THR_W-1:0] thr_q;
  logic [CW-1:0] col_q, col_d, c;
  logic [IMG_H_W-1:0] row_q, row_d;
  logic drain_q, drain_d;
  logic [EW-1:0] d_q, d_d;
  logic [EW-1:0] eff_w, w_ext, col_nx;
  logic [IMG_H_W-1:0] eff_h;
  logic [IMG_H_W:0] row_nx;
  sobel_cmd_t cmd_q, cmd_d;
  logic [CW-1:0] addr_q, addr_d;
  logic [PIX_W-1:0] pix_q;
  logic accept, work, restart;

  // Effective frame size
  assign w_ext = EW'(img_w_q);
  assign eff_w = (img_w_q == '0) ? EW'(1) :
                 (w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext;
  assign eff_h = (img_h_q == '0) ? IMG_H_W'(1) : img_h_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept  = in_valid_i && in_ready_o;
  assign work    = accept && (drain_q || !in_flush_i);
  assign restart = cfg_we_i &&
                   (cfg_index_i == REG_IMG_WIDTH || cfg_index_i == REG_IMG_HEIGHT);

  assign c      = (EW'(col_q) >= eff_w) ? '0 : col_q;
  assign col_nx = EW'(c) + EW'(1);
  assign row_nx = (IMG_H_W+1)'(row_q) + (IMG_H_W+1)'(1);

  // Position, padding and emit decision for the accepted item
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    drain_d = drain_q;
    d_d    = d_q;
    cmd_d  = '0;
    addr_d = c;
    if (!drain_q) begin
      if (c != '0) begin
        cmd_d.emit    = (row_q >= IMG_H_W'(1));
        cmd_d.top_z   = (row_q == IMG_H_W'(1));
        cmd_d.bot_z   = (row_q >= eff_h);
        cmd_d.left_z  = (c == CW'(1));
        cmd_d.right_z = (EW'(c) >= eff_w);
      end else begin
        cmd_d.emit    = (row_q >= IMG_H_W'(2));
        cmd_d.top_z   = (row_q == IMG_H_W'(2));
        cmd_d.bot_z   = ((IMG_H_W+1)'(row_q) >= (IMG_H_W+1)'(eff_h) + (IMG_H_W+1)'(1));
        cmd_d.left_z  = (eff_w == EW'(1));
        cmd_d.right_z = 1'b1;
      end
      if (col_nx >= eff_w) begin
        col_d = '0;
        if (row_nx >= (IMG_H_W+1)'(eff_h)) begin
          row_d   = '0;
          drain_d = 1'b1;
          d_d     = '0;
        end else begin
          row_d = row_nx[IMG_H_W-1:0];
        end
      end else begin
        col_d = col_nx[CW-1:0];
      end
    end else begin
      addr_d = (d_q < eff_w) ? d_q[CW-1:0] : '0;
      if (d_q == '0) begin
        cmd_d.emit    = (eff_h >= IMG_H_W'(2));
        cmd_d.top_z   = (eff_h == IMG_H_W'(2));
        cmd_d.left_z  = (eff_w == EW'(1));
        cmd_d.right_z = 1'b1;
      end else if (d_q < eff_w) begin
        cmd_d.emit    = 1'b1;
        cmd_d.top_z   = (eff_h == IMG_H_W'(1));
        cmd_d.bot_z   = 1'b1;
        cmd_d.left_z  = (d_q == EW'(1));
      end else begin
        cmd_d.emit    = 1'b1;
        cmd_d.top_z   = (eff_h == IMG_H_W'(1));
        cmd_d.bot_z   = 1'b1;
        cmd_d.left_z  = (eff_w == EW'(1));
        cmd_d.right_z = 1'b1;
        cmd_d.last    = 1'b1;
      end
      if (d_q >= eff_w) begin
        drain_d = 1'b0;
        row_d   = '0;
        col_d   = '0;
      end else begin
        d_d = d_q + EW'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_o    = '0;
    op_o.out_drop = restart;
    case (state_q)
      ST_IDLE: begin
        if (work) state_d = ST_RD;
      end
      ST_RD: begin
        op_o.ld_win = 1'b1;
        state_d = cmd_q.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        op_o.ld_grad = 1'b1;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        op_o.ld_sq = 1'b1;
        step_d  = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        op_o.root_step = 1'b1;
        step_d = step_q + 4'd1;
        if (step_q == 4'(ROOT_STEPS - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          op_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      img_w_q <= IMG_W_W'(512);
      img_h_q <= IMG_H_W'(512);
      thr_q   <= THR_W'(70);
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (restart) begin
        col_q   <= '0;
        row_q   <= '0;
        drain_q <= 1'b0;
        d_q     <= '0;
      end else if (work) begin
        col_q   <= col_d;
        row_q   <= row_d;
        drain_q <= drain_d;
        d_q     <= d_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMG_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
          REG_IMG_HEIGHT: img_h_q <= cfg_data_i[IMG_H_W-1:0];
          REG_EDGE_THR:   thr_q   <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item command held while the item is worked on
  always_ff @(posedge clk_i) begin
    if (work) begin
      cmd_q  <= cmd_d;
      addr_q <= addr_d;
      pix_q  <= drain_q ? '0 : in_pix_i;
    end
  end

  assign cmd_o   = cmd_q;
  assign raddr_o = addr_d;
  assign waddr_o = addr_q;
  assign pix_o   = pix_q;
  assign thr_o   = thr_q;

  // Checks
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(col_q) < eff_w) else $error("column past row end");
  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < eff_h) else $error("row past frame end");
  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> d_q <= eff_w) else $error("drain count overrun");
  a_step_only_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> step_q < 4'(ROOT_STEPS)) else $error("root loop overrun");

endmodule
`default_nettype wire

// ===== rtl/sobel_edge_threshold_3x3_top.sv =====
// Channel   | Dir | Signals                          | Content
// s_axis    | in  | tvalid tready tdata[7:0] tuser   | pixel; tuser = flush
// m_axis    | out | tvalid tready tdata[7:0] tlast   | edge_res; tlast = last
// cfg       | in  | cfg_we_i cfg_index_i cfg_data_i  | 0 width, 1 height, 2 threshold
//
// One item at a time. A flush outside the drain is dropped at accept; any
// other item passes through the read state; one that yields a result then
// runs the gradient, square, 11-step square root loop and output states.
// The result waits in an output register, so a new item is taken while
// it is stalled; the next result waits after the loop until that one leaves.
// Reset is asynchronous, active low; line buffers need no clearing since
// every tap read before it is written falls in the padded border.
`default_nettype none
module sobel_edge_threshold_3x3_top import sobel_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel
  input  wire logic                 s_axis_tuser,  // [0] flush
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [PIX_W-1:0]     m_axis_tdata,  // [7:0] edge_res
  output      logic                 m_axis_tlast,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  sobel_op_t        op;
  sobel_cmd_t       cmd;
  sobel_stat_t      stat;
  logic [CW-1:0]    raddr, waddr;
  logic [PIX_W-1:0] pix;
  logic [THR_W-1:0] thr;

  sobel_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_pix_i(s_axis_tdata), .in_flush_i(s_axis_tuser),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .stat_i(stat), .op_o(op), .cmd_o(cmd),
    .raddr_o(raddr), .waddr_o(waddr), .pix_o(pix), .thr_o(thr)
  );

  sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .op_i(op), .cmd_i(cmd), .raddr_i(raddr), .waddr_i(waddr),
    .pix_i(pix), .thr_i(thr), .stat_o(stat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

endmodule
`default_nettype wire
